[rtl/core/cau_pkg.sv]
// Package for the complex arithmetic unit: word widths, operation codes,
// pipeline record types and the saturation helper. Depends on nothing.
package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int ADD_W     = WORD_BITS + 1;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int QB        = WORD_BITS + 1;
  localparam int DSH_W     = PROD_W + QB;
  localparam int IN_W      = 2 + 4 * WORD_BITS;
  localparam int IN_BYTES  = (IN_W + 7) / 8;
  localparam int OUT_W     = 2 * WORD_BITS;

  localparam logic [MAG_W-1:0] MAG_HALF = MAG_W'(1) << (WORD_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_POS  = MAG_HALF - MAG_W'(1);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef struct packed {
    logic                        ovf;
    logic signed [WORD_BITS-1:0] val;
  } sat_t;

  typedef struct packed {
    mode_t             mode;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [NUM_W-1:0]  rem_re;
    logic [NUM_W-1:0]  rem_im;
    logic [QB-1:0]     q_re;
    logic [QB-1:0]     q_im;
    logic [PROD_W-1:0] den;
    sat_t              res_re;
    sat_t              res_im;
  } div_stage_t;

  function automatic sat_t sat_word(logic neg, logic [MAG_W-1:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag > MAG_POS) begin
        r.ovf = 1'b1;
        r.val = MAG_POS[WORD_BITS-1:0];
      end else begin
        r.val = mag[WORD_BITS-1:0];
      end
    end else begin
      if (mag > MAG_HALF) begin
        r.ovf = 1'b1;
        r.val = MAG_HALF[WORD_BITS-1:0];
      end else begin
        r.val = -mag[WORD_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/complex_arith_unit.sv]
// Complex arithmetic unit: add, subtract, multiply and divide of Q8.8 pairs.
// Pipelined multipliers and a one-bit-per-stage restoring divider; uses cau_pkg.
//
//  channel  | dir | contents
//  s_axis   | in  | tdata: mode, a_re, a_im, b_re, b_im
//  m_axis   | out | tdata: res_re, res_im; tuser: overflow, div_zero
//
// One word enters per cycle unless m_axis stalls; each result reaches m_axis through
// the input, product, sum and seed registers,
// 17 divider stages of one quotient bit each, and the output register.
// Reset clears only the valid bits. A stall on m_axis freezes the whole pipe,
// and s_axis_tready drops in the same cycle, so no word is lost or repeated.
module complex_arith_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode[1:0], a_re[17:2], a_im[33:18], b_re[49:34], b_im[65:50], zero fill
  input  logic [cau_pkg::IN_BYTES*8-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // res_re[15:0], res_im[31:16]
  output logic [cau_pkg::OUT_W-1:0]           m_axis_tdata,
  // overflow[0], div_zero[1]
  output logic [1:0]                          m_axis_tuser
);
  import cau_pkg::*;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic                        v1, v2, v3;
  mode_t                       mode1, mode2, mode3;
  logic signed [WORD_BITS-1:0] ar1, ai1, br1, bi1;
  logic signed [PROD_W-1:0]    p_rr, p_ii, p_ir, p_ri, p_bb, p_cc;
  logic signed [ADD_W-1:0]     as_re, as_im;
  logic signed [SUM_W-1:0]     s_re, s_im, s_re_next, s_im_next;
  logic [PROD_W-1:0]           den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode_t'(s_axis_tdata[1:0]);
      ar1   <= s_axis_tdata[2+:WORD_BITS];
      ai1   <= s_axis_tdata[2+WORD_BITS+:WORD_BITS];
      br1   <= s_axis_tdata[2+2*WORD_BITS+:WORD_BITS];
      bi1   <= s_axis_tdata[2+3*WORD_BITS+:WORD_BITS];
      mode2 <= mode1;
      p_rr  <= ar1 * br1;
      p_ii  <= ai1 * bi1;
      p_ir  <= ai1 * br1;
      p_ri  <= ar1 * bi1;
      p_bb  <= br1 * br1;
      p_cc  <= bi1 * bi1;
      if (mode1 == MODE_SUB) begin
        as_re <= ADD_W'(ar1) - ADD_W'(br1);
        as_im <= ADD_W'(ai1) - ADD_W'(bi1);
      end else begin
        as_re <= ADD_W'(ar1) + ADD_W'(br1);
        as_im <= ADD_W'(ai1) + ADD_W'(bi1);
      end
      mode3 <= mode2;
      s_re  <= s_re_next;
      s_im  <= s_im_next;
      den3  <= PROD_W'(unsigned'(p_bb)) + PROD_W'(unsigned'(p_cc));
    end
  end

  always_comb begin
    case (mode2)
      MODE_MUL: begin
        s_re_next = SUM_W'(p_rr) - SUM_W'(p_ii);
        s_im_next = SUM_W'(p_ir) + SUM_W'(p_ri);
      end
      MODE_DIV: begin
        s_re_next = SUM_W'(p_rr) + SUM_W'(p_ii);
        s_im_next = SUM_W'(p_ir) - SUM_W'(p_ri);
      end
      default: begin
        s_re_next = SUM_W'(as_re);
        s_im_next = SUM_W'(as_im);
      end
    endcase
  end

  // Sign and magnitude, then both the final value and the divider seed.
  div_stage_t       pipe [0:QB];
  logic [QB:0]      pv;
  div_stage_t       seed;
  logic [MAG_W-1:0] mag_re, mag_im;

  always_comb begin
    seed.mode   = mode3;
    seed.neg_re = s_re[SUM_W-1];
    seed.neg_im = s_im[SUM_W-1];
    mag_re      = s_re[SUM_W-1] ? MAG_W'(-s_re) : MAG_W'(s_re);
    mag_im      = s_im[SUM_W-1] ? MAG_W'(-s_im) : MAG_W'(s_im);
    seed.den    = den3;
    seed.rem_re = NUM_W'(mag_re) << FRAC_BITS;
    seed.rem_im = NUM_W'(mag_im) << FRAC_BITS;
    seed.big_re = DSH_W'(seed.rem_re >> QB) >= DSH_W'(den3);
    seed.big_im = DSH_W'(seed.rem_im >> QB) >= DSH_W'(den3);
    seed.q_re   = '0;
    seed.q_im   = '0;
    if (mode3 == MODE_MUL) begin
      seed.res_re = sat_word(seed.neg_re, mag_re >> FRAC_BITS);
      seed.res_im = sat_word(seed.neg_im, mag_im >> FRAC_BITS);
    end else begin
      seed.res_re = sat_word(seed.neg_re, mag_re);
      seed.res_im = sat_word(seed.neg_im, mag_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= seed;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    div_stage_t       nxt;
    logic [DSH_W-1:0] dsh;

    always_comb begin
      nxt = pipe[j];
      dsh = DSH_W'(pipe[j].den) << K;
      if (DSH_W'(pipe[j].rem_re) >= dsh) begin
        nxt.rem_re  = pipe[j].rem_re - dsh[NUM_W-1:0];
        nxt.q_re[K] = 1'b1;
      end
      if (DSH_W'(pipe[j].rem_im) >= dsh) begin
        nxt.rem_im  = pipe[j].rem_im - dsh[NUM_W-1:0];
        nxt.q_im[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[j+1] <= 1'b0;
      end else if (en) begin
        pv[j+1] <= pv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[j+1] <= nxt;
      end
    end
  end

  div_stage_t last;
  sat_t       fin_re, fin_im;
  logic       dz;

  always_comb begin
    last   = pipe[QB];
    fin_re = last.res_re;
    fin_im = last.res_im;
    dz     = 1'b0;
    if (last.mode == MODE_DIV) begin
      if (last.den == '0) begin
        dz     = 1'b1;
        fin_re = '0;
        fin_im = '0;
      end else begin
        fin_re = sat_word(last.neg_re, last.big_re ? '1 : MAG_W'(last.q_re));
        fin_im = sat_word(last.neg_im, last.big_im ? '1 : MAG_W'(last.q_im));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= pv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {fin_im.val, fin_re.val};
      m_axis_tuser <= {dz, fin_re.ovf | fin_im.ovf};
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("divide by zero word carries a nonzero result or overflow");

  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[WORD_BITS-1:0] == MAG_POS[WORD_BITS-1:0] ||
       m_axis_tdata[WORD_BITS-1:0] == MAG_HALF[WORD_BITS-1:0] ||
       m_axis_tdata[OUT_W-1:WORD_BITS] == MAG_POS[WORD_BITS-1:0] ||
       m_axis_tdata[OUT_W-1:WORD_BITS] == MAG_HALF[WORD_BITS-1:0]))
    else $error("overflow flagged without a saturated part");

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pv))
    else $error("pipeline moved during a stall");

endmodule
